FILE: rtl/gscc_pkg.sv
// ----------------------------------------------------------------------------
// gscc_pkg
// Shared types and constants for the grid segment collision check.
// ----------------------------------------------------------------------------
`default_nettype none

package gscc_pkg;

  localparam int COORD_W     = 9;
  localparam int GRID_SIDE   = 1 << COORD_W;
  localparam int SIDE_W      = COORD_W + 1;
  localparam int AREA_RADIUS = 2;
  localparam int AREA_SPAN   = 2 * AREA_RADIUS + 1;
  localparam int SPAN_W      = $clog2(AREA_SPAN);
  localparam int REM_W       = COORD_W + 3;

  localparam logic [SIDE_W-1:0] MAP_SIZE_RESET = SIDE_W'(GRID_SIDE);

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_SEGMENT = 2'd1;
  localparam logic [1:0] KIND_AREA    = 2'd2;

  localparam logic QK_SEGMENT = 1'b0;
  localparam logic QK_AREA    = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic               cell_blocked;
  } in_word_t;

  typedef struct packed {
    logic path_clear;
    logic query_kind;
  } out_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } step_pos_t;

endpackage

`default_nettype wire

FILE: rtl/gscc_occ_mem.sv
// ----------------------------------------------------------------------------
// gscc_occ_mem
// Occupancy store: one row of cells per x, one read and one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module gscc_occ_mem (
  input  wire logic                           clk,
  input  wire logic                           rd_en,
  input  wire logic [gscc_pkg::COORD_W-1:0]   rd_addr,
  output logic      [gscc_pkg::GRID_SIDE-1:0] rd_data,
  input  wire logic                           wr_en,
  input  wire logic [gscc_pkg::COORD_W-1:0]   wr_addr,
  input  wire logic [gscc_pkg::GRID_SIDE-1:0] wr_data
);
  import gscc_pkg::*;

  logic [GRID_SIDE-1:0] mem [GRID_SIDE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gscc_line_step.sv
// ----------------------------------------------------------------------------
// gscc_line_step
// Exact segment stepper: one rounded sample point per advance.
// ----------------------------------------------------------------------------
`default_nettype none

module gscc_line_step (
  input  wire logic                         clk,
  input  wire logic                         load,
  input  wire logic                         advance,
  input  wire logic [gscc_pkg::COORD_W-1:0] start_x,
  input  wire logic [gscc_pkg::COORD_W-1:0] start_y,
  input  wire logic [gscc_pkg::COORD_W-1:0] end_x,
  input  wire logic [gscc_pkg::COORD_W-1:0] end_y,
  output gscc_pkg::step_pos_t               pos
);
  import gscc_pkg::*;

  logic signed [SIDE_W-1:0] dx, dy;
  logic        [SIDE_W-1:0] ax, ay;
  logic        [COORD_W-1:0] n_ld;

  logic        [COORD_W-1:0] x_r, y_r, n_r, k_r;
  logic signed [REM_W-1:0]   rx_r, ry_r, two_dx_r, two_dy_r, two_n_r;

  logic        [COORD_W-1:0] x_nxt, y_nxt;
  logic signed [REM_W-1:0]   rx_nxt, ry_nxt, rx_sum, ry_sum;

  always_comb begin
    dx   = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
    dy   = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
    ax   = dx[SIDE_W-1] ? SIDE_W'(-dx) : SIDE_W'(dx);
    ay   = dy[SIDE_W-1] ? SIDE_W'(-dy) : SIDE_W'(dy);
    n_ld = (ax > ay) ? ax[COORD_W-1:0] : ay[COORD_W-1:0];
  end

  always_comb begin
    rx_sum = rx_r + two_dx_r;
    ry_sum = ry_r + two_dy_r;
    x_nxt  = x_r;
    y_nxt  = y_r;
    rx_nxt = rx_sum;
    ry_nxt = ry_sum;
    if (!two_dx_r[REM_W-1] && (rx_sum >= two_n_r)) begin
      rx_nxt = rx_sum - two_n_r;
      x_nxt  = x_r + 1'b1;
    end else if (two_dx_r[REM_W-1] && rx_sum[REM_W-1]) begin
      rx_nxt = rx_sum + two_n_r;
      x_nxt  = x_r - 1'b1;
    end
    if (!two_dy_r[REM_W-1] && (ry_sum >= two_n_r)) begin
      ry_nxt = ry_sum - two_n_r;
      y_nxt  = y_r + 1'b1;
    end else if (two_dy_r[REM_W-1] && ry_sum[REM_W-1]) begin
      ry_nxt = ry_sum + two_n_r;
      y_nxt  = y_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r      <= start_x;
      y_r      <= start_y;
      n_r      <= n_ld;
      k_r      <= '0;
      rx_r     <= $signed(REM_W'(n_ld));
      ry_r     <= $signed(REM_W'(n_ld));
      two_dx_r <= $signed({{(REM_W-SIDE_W-1){dx[SIDE_W-1]}}, dx, 1'b0});
      two_dy_r <= $signed({{(REM_W-SIDE_W-1){dy[SIDE_W-1]}}, dy, 1'b0});
      two_n_r  <= $signed({{(REM_W-COORD_W-1){1'b0}}, n_ld, 1'b0});
    end else if (advance) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
      k_r  <= k_r + 1'b1;
    end
  end

  assign pos.x    = x_r;
  assign pos.y    = y_r;
  assign pos.last = (k_r == n_r);

endmodule

`default_nettype wire

FILE: rtl/grid_segment_collision_check.sv
// ----------------------------------------------------------------------------
// grid_segment_collision_check
// Write: row read (ST_WR_RD), then write-back (ST_WR_WB). Segment query: one cell read per cycle.
// Area query: one grid row read per cycle, rows off the grid skipped; none if the center is off grid.
// One item at a time; a finished answer waits in an output register.
// Reset: clearing pass over every occupancy row, no items taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_segment_collision_check (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire gscc_pkg::in_word_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output gscc_pkg::out_word_t               out_data,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [gscc_pkg::SIDE_W-1:0]  cfg_data
);
  import gscc_pkg::*;

  localparam int RW = COORD_W + 2;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_WR_RD, ST_WR_WB, ST_SEG, ST_AREA, ST_DRAIN, ST_DONE
  } state_t;

  state_t               state_r;
  in_word_t             item_r;
  logic [SIDE_W-1:0]    map_size_r;
  logic [COORD_W-1:0]   clr_cnt_r;
  logic [SPAN_W-1:0]    span_r;
  logic                 clear_r;
  logic                 p_vld_r, p_oob_r, p_area_r;
  logic [COORD_W-1:0]   p_y_r;
  logic                 out_vld_r;
  out_word_t            out_r;

  logic [SIDE_W-1:0]    side;
  logic                 in_acc;
  logic                 rd_en, wr_en;
  logic [COORD_W-1:0]   rd_addr, wr_addr;
  logic [GRID_SIDE-1:0] rd_data, wr_data;
  step_pos_t            pos;
  logic                 step_load, step_adv;
  logic [RW-1:0]        row_v;
  logic                 row_ok, center_oob, seg_oob;
  logic                 area_hit, hit;
  logic [RW-1:0]        yv;
  logic                 p_vld_nxt;

  gscc_occ_mem u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  gscc_line_step u_step (
    .clk     (clk),
    .load    (step_load),
    .advance (step_adv),
    .start_x (in_data.start_x),
    .start_y (in_data.start_y),
    .end_x   (in_data.end_x),
    .end_y   (in_data.end_y),
    .pos     (pos)
  );

  assign side      = (map_size_r > SIDE_W'(GRID_SIDE)) ? SIDE_W'(GRID_SIDE) : map_size_r;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign step_load = in_acc && (in_data.kind == KIND_SEGMENT);
  assign step_adv  = (state_r == ST_SEG) && !pos.last;

  assign center_oob = ({1'b0, in_data.start_x} >= side) || ({1'b0, in_data.start_y} >= side);
  assign seg_oob    = ({1'b0, pos.x} >= side) || ({1'b0, pos.y} >= side);
  assign p_vld_nxt  = (state_r == ST_SEG) || ((state_r == ST_AREA) && row_ok);

  always_comb begin
    row_v  = RW'(item_r.start_x) + RW'(span_r) - RW'(AREA_RADIUS);
    row_ok = !row_v[RW-1] && (row_v[SIDE_W-1:0] < side);
  end

  always_comb begin
    area_hit = 1'b0;
    yv       = '0;
    for (int j = 0; j < AREA_SPAN; j++) begin
      yv = RW'(item_r.start_y) + RW'(j) - RW'(AREA_RADIUS);
      if (!yv[RW-1] && (yv[SIDE_W-1:0] < side) && rd_data[yv[COORD_W-1:0]]) begin
        area_hit = 1'b1;
      end
    end
    hit = p_area_r ? area_hit : (p_oob_r || rd_data[p_y_r]);
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = item_r.start_x;
    wr_en   = 1'b0;
    wr_addr = item_r.start_x;
    wr_data = rd_data;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = '0;
      end
      ST_WR_RD: begin
        rd_en = 1'b1;
      end
      ST_WR_WB: begin
        wr_en                   = 1'b1;
        wr_data[item_r.start_y] = item_r.cell_blocked;
      end
      ST_SEG: begin
        rd_en   = 1'b1;
        rd_addr = pos.x;
      end
      ST_AREA: begin
        rd_en   = row_ok;
        rd_addr = row_v[COORD_W-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_size_r <= MAP_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      map_size_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      p_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      p_vld_r <= p_vld_nxt;
      if (out_vld_r && out_ready && (state_r != ST_DONE)) begin
        out_vld_r <= 1'b0;
      end
      if (p_vld_r && hit) begin
        clear_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (&clr_cnt_r) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            item_r  <= in_data;
            clear_r <= !((in_data.kind == KIND_AREA) && center_oob);
            span_r  <= '0;
            case (in_data.kind)
              KIND_WRITE: begin
                state_r <= ST_WR_RD;
              end
              KIND_SEGMENT: begin
                state_r <= ST_SEG;
              end
              KIND_AREA: begin
                if (center_oob) begin
                  state_r <= ST_DONE;
                end else begin
                  state_r <= ST_AREA;
                end
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_WR_RD: begin
          state_r <= ST_WR_WB;
        end
        ST_WR_WB: begin
          state_r <= ST_IDLE;
        end
        ST_SEG: begin
          p_area_r <= 1'b0;
          p_oob_r  <= seg_oob;
          p_y_r    <= pos.y;
          if (pos.last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_AREA: begin
          p_area_r <= 1'b1;
          p_oob_r  <= 1'b0;
          span_r   <= span_r + 1'b1;
          if (span_r == SPAN_W'(AREA_SPAN - 1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_vld_r || out_ready) begin
            out_vld_r        <= 1'b1;
            out_r.path_clear <= clear_r;
            out_r.query_kind <= (item_r.kind == KIND_AREA) ? QK_AREA : QK_SEGMENT;
            state_r          <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
